[rtl/core/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the PNG scanline unfilter
// Sizes of the line store and pixel history, filter codes, register indexes
// and the work entry that travels from front to back.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int MAX_LINE_BYTES  = 8192;
   localparam int MAX_PIXEL_BYTES = 8;

   // field and register widths
   localparam int BYTE_W    = 8;
   localparam int LINE_W    = 14;
   localparam int PIX_W     = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 14;

   // line store index, and a length that can hold MAX_LINE_BYTES itself
   localparam int IDX_W     = $clog2(MAX_LINE_BYTES);
   localparam int LB_W      = IDX_W + 1;
   localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BYTES = 1'b1;

   // filter types of a scanline
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [BYTE_W-1:0] FILT_MAX_CODE = 8'd4;

   // one data byte, classified by the front
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  idx;
      logic              last;
      logic              first_row;
      filter_type        filter;
      logic              invalid;
   } psu_entry_type;

endpackage

[rtl/core/psu_front.sv]
// ----------------------------------------------------------------------------
// psu_front: scanline framing
// Accepts stream beats, takes the filter byte of each line, and tags every
// data byte with its column, line end and filter before queueing it.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [BYTE_W-1:0]   req_tdata,   // [7:0] stream_byte
   input  logic                req_tuser,   // [0] image_start
   input  logic [LB_W-1:0]     line_len,
   output logic                push_valid,
   output psu_entry_type       push_entry,
   input  logic                queue_full
);

   logic             awaiting_ff, awaiting_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   filter_type       filter_ff, filter_in;
   logic             invalid_ff, invalid_in;
   logic             first_row_ff, first_row_in;
   logic             accept;
   logic             last;

   // a filter byte never needs a queue slot
   assign req_tready = awaiting_ff || !queue_full;
   assign accept     = req_tvalid && req_tready;

   // line end when the data index reaches the current length minus one
   assign last = ((LB_W'(idx_ff) + LB_W'(1)) >= line_len);

   // build the queue entry
   always_comb begin
      push_valid           = accept && !awaiting_ff;
      push_entry.data      = req_tdata;
      push_entry.idx       = idx_ff;
      push_entry.last      = last;
      push_entry.first_row = first_row_ff;
      push_entry.filter    = filter_ff;
      push_entry.invalid   = invalid_ff;
   end

   // advance the line position
   always_comb begin
      awaiting_in  = awaiting_ff;
      idx_in       = idx_ff;
      filter_in    = filter_ff;
      invalid_in   = invalid_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (awaiting_ff) begin
            if (req_tuser) begin
               first_row_in = 1'b1;
            end
            if (req_tdata > FILT_MAX_CODE) begin
               invalid_in = 1'b1;
               filter_in  = FILT_NONE;
            end else begin
               invalid_in = 1'b0;
               filter_in  = filter_type'(req_tdata[2:0]);
            end
            awaiting_in = 1'b0;
            idx_in      = '0;
         end else if (last) begin
            awaiting_in  = 1'b1;
            first_row_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b1;
         idx_ff       <= '0;
         filter_ff    <= FILT_NONE;
         invalid_ff   <= 1'b0;
         first_row_ff <= 1'b1;
      end else begin
         awaiting_ff  <= awaiting_in;
         idx_ff       <= idx_in;
         filter_ff    <= filter_in;
         invalid_ff   <= invalid_in;
         first_row_ff <= first_row_in;
      end
   end

endmodule

[rtl/core/psu_queue.sv]
// ----------------------------------------------------------------------------
// psu_queue: two-entry queue between front and back
// Decouples the framing side from the reconstruction side.
// ----------------------------------------------------------------------------
module psu_queue import psu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  psu_entry_type push_entry,
   output logic          full,
   output logic          pop_valid,
   output psu_entry_type pop_entry,
   input  logic          pop
);

   psu_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/psu_back.sv]
// ----------------------------------------------------------------------------
// psu_back: byte reconstruction
// Reads the row above from the line store, undoes the filter against the
// pixel history, writes the row back and holds the result beat.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  psu_entry_type        pop_entry,
   output logic                 pop,
   input  logic [PIX_IDX_W-1:0] pix_sel,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,   // [7:0] pixel_byte
   output logic                 rsp_tlast,   // line_end
   output logic                 rsp_tuser    // [0] bad_filter
);

   // line store of the previous row
   logic [BYTE_W-1:0] row_mem [MAX_LINE_BYTES];

   // read stage
   logic              s1_valid_ff, s1_valid_in;
   psu_entry_type     s1_entry_ff;
   logic [BYTE_W-1:0] s1_rd_ff;
   logic              s1_byp_ff;
   logic [BYTE_W-1:0] s1_byp_data_ff;

   // pixel history, newest byte at index 0
   logic [BYTE_W-1:0] left_ff [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0] ul_ff   [MAX_PIXEL_BYTES];

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;
   logic              out_bad_ff;

   logic              out_free, s1_fire, s1_load;
   logic [BYTE_W-1:0] up, left, ul, val;

   function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
      logic [BYTE_W+1:0] sa, sb, sc, s_ab, s_cc;
      logic [BYTE_W+1:0] da, db, dc;
      sa   = {2'b00, a};
      sb   = {2'b00, b};
      sc   = {2'b00, c};
      s_ab = sa + sb;
      s_cc = sc + sc;
      da   = (sb >= sc) ? sb - sc : sc - sb;
      db   = (sa >= sc) ? sa - sc : sc - sa;
      dc   = (s_ab >= s_cc) ? s_ab - s_cc : s_cc - s_ab;
      if (da <= db && da <= dc) begin
         return a;
      end else if (db <= dc) begin
         return b;
      end
      return c;
   endfunction

   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_fire  = s1_valid_ff && out_free;
   assign s1_load  = pop_valid && (!s1_valid_ff || s1_fire);
   assign pop      = s1_load;

   // pick neighbors; history from an earlier line counts as zero
   always_comb begin
      up   = s1_entry_ff.first_row ? '0 : (s1_byp_ff ? s1_byp_data_ff : s1_rd_ff);
      left = (s1_entry_ff.idx == '0) ? '0 : left_ff[pix_sel];
      ul   = (s1_entry_ff.idx == '0) ? '0 : ul_ff[pix_sel];
   end

   // undo the filter
   always_comb begin
      logic [BYTE_W:0] avg_sum;
      avg_sum = {1'b0, left} + {1'b0, up};
      if (s1_entry_ff.invalid) begin
         val = s1_entry_ff.data;
      end else begin
         case (s1_entry_ff.filter)
            FILT_SUB:   val = s1_entry_ff.data + left;
            FILT_UP:    val = s1_entry_ff.data + up;
            FILT_AVG:   val = s1_entry_ff.data + avg_sum[BYTE_W:1];
            FILT_PAETH: val = s1_entry_ff.data + paeth(left, up, ul);
            default:    val = s1_entry_ff.data;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // line store: write the finished byte, read the next entry's column
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         row_mem[s1_entry_ff.idx] <= val;
      end
      if (s1_load) begin
         s1_rd_ff <= row_mem[pop_entry.idx];
      end
   end

   // load the read stage; forward a byte written at the column being read
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_entry_ff    <= pop_entry;
         s1_byp_ff      <= s1_fire && (pop_entry.idx == s1_entry_ff.idx);
         s1_byp_data_ff <= val;
      end
   end

   // shift the pixel history; restart it on the first byte of a line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i] <= '0;
            ul_ff[i]   <= '0;
         end
      end else if (s1_fire) begin
         left_ff[0] <= val;
         ul_ff[0]   <= up;
         for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i] <= (s1_entry_ff.idx == '0) ? '0 : left_ff[i-1];
            ul_ff[i]   <= (s1_entry_ff.idx == '0) ? '0 : ul_ff[i-1];
         end
      end
   end

   // hold the result beat
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_byte_ff <= val;
         out_last_ff <= s1_entry_ff.last;
         out_bad_ff  <= s1_entry_ff.invalid;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

[rtl/core/png_scanline_unfilter.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG scanline reconstruction
// Removes the per-line filter from an inflated PNG byte stream.
// ----------------------------------------------------------------------------
// Each scanline arrives as one filter-type byte followed by line_bytes data
// bytes; the filter byte yields no output beat, every data byte yields one
// reconstructed byte with line_end on the last byte of the line and
// bad_filter set on every byte of a line whose filter type exceeds 4 (those
// bytes pass through unchanged). Set image_start on the filter byte of an
// image's first row. The block takes one byte per cycle while the output
// is not stalled; a data byte passes through the queue slot, the line
// store read register and the output register. The rate is set by the
// left-neighbour feedback: the Paeth predictor and the final add are
// combinational between the line store read register and the output
// register. The line store is not cleared after reset, so the block is
// ready at once; the first row of an image reads the row above as zero.
// Change line_bytes and pixel_bytes only while no beat is in flight; a
// change applies from the next byte accepted.
// ----------------------------------------------------------------------------
module png_scanline_unfilter import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,    // [7:0] stream_byte
   input  logic                 req_tuser,    // [0] image_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,    // [7:0] pixel_byte
   output logic                 rsp_tlast,    // line_end
   output logic                 rsp_tuser,    // [0] bad_filter
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   logic [LINE_W-1:0]    line_bytes_ff;
   logic [PIX_W-1:0]     pixel_bytes_ff;
   logic [LB_W-1:0]      line_len;
   logic [PIX_IDX_W-1:0] pix_sel;

   logic          push_valid, queue_full, pop_valid, pop;
   psu_entry_type push_entry, pop_entry;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff  <= LINE_W'(1);
         pixel_bytes_ff <= PIX_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_BYTES:  line_bytes_ff  <= csr_wr_data[LINE_W-1:0];
            CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_wr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the line length and the pixel distance to what the store holds
   always_comb begin
      if (line_bytes_ff == '0) begin
         line_len = LB_W'(1);
      end else if (int'(line_bytes_ff) > MAX_LINE_BYTES) begin
         line_len = LB_W'(MAX_LINE_BYTES);
      end else begin
         line_len = LB_W'(line_bytes_ff);
      end
      if (pixel_bytes_ff == '0) begin
         pix_sel = '0;
      end else if (int'(pixel_bytes_ff) > MAX_PIXEL_BYTES) begin
         pix_sel = PIX_IDX_W'(MAX_PIXEL_BYTES - 1);
      end else begin
         pix_sel = PIX_IDX_W'(pixel_bytes_ff - PIX_W'(1));
      end
   end

   psu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .line_len   (line_len),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   psu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   psu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .pix_sel    (pix_sel),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/core/psu_checker.sv]
// ----------------------------------------------------------------------------
// psu_checker: port-level checks of the scanline unfilter
// Watches the stream ports for reset, stall, ordering and line flag faults.
module psu_checker import psu_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [BYTE_W-1:0]    rsp_tdata,
   input logic                 rsp_tlast,
   input logic                 rsp_tuser
);

   logic [31:0] req_cnt_ff;
   logic [31:0] rsp_cnt_ff;
   logic        mid_line_ff;
   logic        line_bad_ff;
   logic        req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // count beats and track the flag of the line in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         req_cnt_ff  <= '0;
         rsp_cnt_ff  <= '0;
         mid_line_ff <= 1'b0;
         line_bad_ff <= 1'b0;
      end else begin
         if (req_beat) begin
            req_cnt_ff <= req_cnt_ff + 32'd1;
         end
         if (rsp_beat) begin
            rsp_cnt_ff  <= rsp_cnt_ff + 32'd1;
            mid_line_ff <= !rsp_tlast;
            line_bad_ff <= rsp_tuser;
         end
      end
   end

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // every result beat comes after more input beats than results so far
   assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (req_cnt_ff > rsp_cnt_ff))
      else $error("result beat without a matching input beat");

   // the bad filter flag stays constant over a line
   assert property (@(posedge clock) disable iff (reset)
      rsp_beat && mid_line_ff |-> (rsp_tuser == line_bad_ff))
      else $error("bad filter flag changed within a line");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);
